// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers clocked on aclk and disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/mlbc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlbc_pkg
// types and constants shared by the led blink code controller
// ----------------------------------------------------------------------------
package mlbc_pkg;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_ON    = 3'd1,
        M_OFF   = 3'd2,
        M_BLINK = 3'd3,
        M_CODE  = 3'd4,
        M_PAUSE = 3'd5
    } led_mode_t;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_ON    = 3'd1;
    localparam logic [2:0] CMD_OFF   = 3'd2;
    localparam logic [2:0] CMD_BLINK = 3'd3;
    localparam logic [2:0] CMD_CODE  = 3'd4;

    localparam logic REG_CODE_STEP  = 1'b0;
    localparam logic REG_CODE_PAUSE = 1'b1;

    localparam logic [15:0] CODE_STEP_RESET  = 16'd400;
    localparam logic [15:0] CODE_PAUSE_RESET = 16'd3000;
    localparam logic [16:0] ELAPSED_TOP      = 17'h1FFFF;

    localparam int IN_BITS = 38;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PROC = 2'd1,
        ST_DONE = 2'd2
    } ctrl_state_t;

    // first member is the top bits, so mode lands in the low bits
    typedef struct packed {
        logic [7:0]  code_value;
        logic [7:0]  stretch_steps;
        logic [15:0] blink_period;
        logic [2:0]  led_index;
        logic [2:0]  mode;
    } item_t;

    typedef struct packed {
        led_mode_t   cur_mode;
        led_mode_t   prev_mode;
        led_mode_t   next_mode;
        logic [16:0] elapsed;
        logic [15:0] period_store;
        logic [7:0]  stretch_limit;
        logic [7:0]  stretch_count;
        logic        phase_flag;
        logic [7:0]  code_store;
        logic [8:0]  code_progress;
    } led_rec_t;

    typedef struct packed {
        logic en;
        logic on;
    } drive_t;

endpackage

// ===== sv/mlbc_rec_update.sv =====
// ----------------------------------------------------------------------------
// mlbc_rec_update
// next value of one led record for a tick or a command beat
// ----------------------------------------------------------------------------
module mlbc_rec_update import mlbc_pkg::*; (
    input  item_t       item,
    input  logic [15:0] code_step,
    input  logic [15:0] code_pause,
    input  led_rec_t    rec_in,
    output led_rec_t    rec_out,
    output drive_t      drive
);

    always_comb begin
        led_rec_t r;
        r = rec_in;
        drive = '0;
        if (item.mode == CMD_TICK) begin
            if (r.elapsed < ELAPSED_TOP) begin
                r.elapsed = r.elapsed + 17'd1;
            end
            unique case (r.cur_mode)
                M_ON: begin
                    if (r.prev_mode != M_ON) begin
                        drive = '{en: 1'b1, on: 1'b1};
                        r.next_mode = M_ON;
                    end
                end
                M_OFF: begin
                    if (r.prev_mode != M_OFF) begin
                        drive = '{en: 1'b1, on: 1'b0};
                        r.next_mode = M_OFF;
                    end
                end
                M_BLINK: begin
                    if (r.prev_mode != M_BLINK) begin
                        r.elapsed = '0;
                        r.next_mode = M_BLINK;
                    end
                    if (r.elapsed > {1'b0, r.period_store}) begin
                        r.elapsed = '0;
                        if (!r.phase_flag) begin
                            drive = '{en: 1'b1, on: 1'b0};
                            r.phase_flag = 1'b1;
                        end else if (r.stretch_limit == 8'd0) begin
                            drive = '{en: 1'b1, on: 1'b1};
                            r.phase_flag = 1'b0;
                        end else if (r.stretch_count >= r.stretch_limit) begin
                            r.stretch_count = '0;
                            drive = '{en: 1'b1, on: 1'b1};
                            r.phase_flag = 1'b0;
                        end else begin
                            r.stretch_count = r.stretch_count + 8'd1;
                        end
                    end
                end
                M_CODE: begin
                    if (r.prev_mode != M_CODE) begin
                        r.elapsed = '0;
                        r.phase_flag = 1'b1;
                        r.code_progress = '0;
                    end
                    if (r.elapsed > {1'b0, code_step}) begin
                        r.elapsed = '0;
                        drive = '{en: 1'b1, on: r.phase_flag};
                        r.phase_flag = !r.phase_flag;
                        if (r.code_progress < {r.code_store, 1'b0}) begin
                            r.code_progress = r.code_progress + 9'd1;
                            r.next_mode = M_CODE;
                        end else begin
                            drive = '{en: 1'b1, on: 1'b0};
                            r.next_mode = M_PAUSE;
                        end
                    end
                end
                M_PAUSE: begin
                    if (r.prev_mode != M_PAUSE) begin
                        r.elapsed = '0;
                        r.phase_flag = 1'b0;
                    end
                    if (r.elapsed > {1'b0, code_pause}) begin
                        r.next_mode = M_CODE;
                    end
                end
                default: begin
                end
            endcase
            r.prev_mode = r.cur_mode;
            r.cur_mode = r.next_mode;
        end else begin
            unique case (item.mode)
                CMD_ON:  r.cur_mode = M_ON;
                CMD_OFF: r.cur_mode = M_OFF;
                CMD_BLINK: begin
                    if (r.prev_mode != M_BLINK) begin
                        r.elapsed = '0;
                        r.cur_mode = M_BLINK;
                    end
                    r.period_store = item.blink_period;
                    r.stretch_limit = item.stretch_steps;
                end
                CMD_CODE: begin
                    if (r.prev_mode != M_CODE) begin
                        r.elapsed = '0;
                        r.cur_mode = M_CODE;
                        r.next_mode = M_CODE;
                    end
                    r.code_store = item.code_value;
                    r.code_progress = '0;
                end
                default: begin
                end
            endcase
        end
        rec_out = r;
    end

endmodule

// ===== sv/multi_led_blink_code_controller_top.sv =====
// ----------------------------------------------------------------------------
// multi_led_blink_code_controller_top
// per-led records live in one synchronous memory; a tick walks every record
// a beat is read in ST_IDLE, updated and written back in ST_PROC (a tick walks
// every record there), and its levels load into the output register in ST_DONE
// once that is free; s_tready is low until then, so beats are taken one at a time
// reset: synchronous, records read as zero through per-entry valid bits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_led_blink_code_controller_top import mlbc_pkg::*; #(
    parameter int NUM_LEDS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode, led_index, blink_period, stretch_steps, code_value, zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // led_levels
    output logic [7:0]  m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [LED_W-1:0] LAST_LED = LED_W'(NUM_LEDS - 1);

    ctrl_state_t       state_reg, state_next;
    item_t             item_reg;
    logic [LED_W-1:0]  proc_addr_reg, proc_addr_next;
    logic [7:0]        levels_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic [15:0]       code_step_reg, code_pause_reg;
    logic [NUM_LEDS-1:0] valid_reg;
    led_rec_t          rd_data_reg;
    logic              rd_valid_reg;

    led_rec_t          mem [NUM_LEDS];

    logic              rd_en, wr_en, load_out;
    logic [LED_W-1:0]  rd_addr;
    logic              is_tick, cmd_ok;
    led_rec_t          rec_cur, rec_new;
    drive_t            drive;
    item_t             s_item;
    logic [2:0]        lvl_idx;
    logic              lvl_vis;

    assign s_item  = item_t'(s_tdata[IN_BITS-1:0]);
    assign is_tick = (item_reg.mode == CMD_TICK);
    assign cmd_ok  = (item_reg.mode == CMD_ON || item_reg.mode == CMD_OFF ||
                      item_reg.mode == CMD_BLINK || item_reg.mode == CMD_CODE) &&
                     (32'(item_reg.led_index) < NUM_LEDS);
    assign rec_cur = rd_valid_reg ? rd_data_reg : led_rec_t'('0);
    assign lvl_idx = 3'(proc_addr_reg);
    assign lvl_vis = (32'(proc_addr_reg) < 8);

    mlbc_rec_update u_update (
        .item       (item_reg),
        .code_step  (code_step_reg),
        .code_pause (code_pause_reg),
        .rec_in     (rec_cur),
        .rec_out    (rec_new),
        .drive      (drive)
    );

    always_comb begin
        state_next     = state_reg;
        proc_addr_next = proc_addr_reg;
        rd_en          = 1'b0;
        rd_addr        = proc_addr_reg;
        wr_en          = 1'b0;
        s_tready       = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    rd_en = 1'b1;
                    rd_addr = (s_item.mode == CMD_TICK) ? '0 : LED_W'(s_item.led_index);
                    proc_addr_next = rd_addr;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                wr_en = is_tick || cmd_ok;
                if (is_tick && proc_addr_reg != LAST_LED) begin
                    rd_en = 1'b1;
                    rd_addr = proc_addr_reg + LED_W'(1);
                    proc_addr_next = rd_addr;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            levels_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            code_step_reg  <= CODE_STEP_RESET;
            code_pause_reg <= CODE_PAUSE_RESET;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_addr == REG_CODE_STEP) begin
                    code_step_reg <= cfg_wdata;
                end else begin
                    code_pause_reg <= cfg_wdata;
                end
            end
            if (wr_en) begin
                valid_reg[proc_addr_reg] <= 1'b1;
                if (drive.en && lvl_vis) begin
                    levels_reg[lvl_idx] <= drive.on;
                end
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        proc_addr_reg <= proc_addr_next;
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
        if (load_out) begin
            m_tdata_reg <= levels_reg;
        end
    end

    // record memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[proc_addr_reg] <= rec_new;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_IMPLIES(a_proc_reads_own_entry, state_reg == ST_PROC,
        $past(rd_en) && $past(rd_addr) == proc_addr_reg, "record data not from processed entry")
    `ASSERT_IMPLIES(a_tick_addr_in_range, state_reg == ST_PROC && is_tick,
        32'(proc_addr_reg) < NUM_LEDS, "tick walk beyond last led")
    `ASSERT_NEXT(a_result_is_levels, load_out,
        m_tvalid_reg && m_tdata_reg == levels_reg, "result beat differs from led levels")

endmodule

// ===== verif/multi_led_blink_code_controller_top_test.sv =====
// ----------------------------------------------------------------------------
// multi_led_blink_code_controller_top_test
// Drives command and tick beats into the LED controller and checks every
// returned LED level word against a typed table entry or an in-bench model
// of the LED records. A directed table comes first, then random beats under
// several code step and pause settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module multi_led_blink_code_controller_top_test import mlbc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEDS    = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = NUM_LEDS + 6;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_BEATS = 100;

    localparam logic [2:0] CMD_BAD_LO  = 3'd5;
    localparam logic [2:0] CMD_BAD_MID = 3'd6;
    localparam logic [2:0] CMD_BAD_HI  = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // mode, led_index, blink_period, stretch_steps, code_value, zero fill
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // led_levels
    logic [7:0]  m_tdata;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    multi_led_blink_code_controller_top #(.NUM_LEDS(NUM_LEDS)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // model of the led records
    led_mode_t   cur_m   [NUM_LEDS];
    led_mode_t   prev_m  [NUM_LEDS];
    led_mode_t   nxt_m   [NUM_LEDS];
    logic [16:0] elap    [NUM_LEDS];
    logic [15:0] per_st  [NUM_LEDS];
    logic [7:0]  str_lim [NUM_LEDS];
    logic [7:0]  str_cnt [NUM_LEDS];
    logic        phase   [NUM_LEDS];
    logic [7:0]  code_st [NUM_LEDS];
    logic [8:0]  prog    [NUM_LEDS];
    logic [7:0]  lit;
    logic [15:0] step_cfg;
    logic [15:0] pause_cfg;

    logic [7:0] pending_levels [$];
    logic [7:0] want_levels;

    int err_cnt;
    int beat_cnt;
    int tick_cnt;
    int cmd_cnt;
    int result_cnt;
    int setting_cnt;
    int hold_cnt;
    int cyc;
    int snd_calm;
    int rcv_calm;
    int rcv_stall;
    bit hold_req;

    typedef struct {
        logic [2:0]  mode;
        logic [2:0]  idx;
        logic [15:0] period;
        logic [7:0]  stretch;
        logic [7:0]  code;
        bit          typed;
        logic [7:0]  levels;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{CMD_TICK,    3'd7, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'h00},
        '{CMD_ON,      3'd0, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h01},
        '{CMD_ON,      3'd7, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h01},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h81},
        '{CMD_BAD_LO,  3'd0, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'h81},
        '{CMD_BAD_MID, 3'd3, 16'h1234, 8'h5A, 8'hA5, 1'b1, 8'h81},
        '{CMD_BAD_HI,  3'd7, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'h81},
        '{CMD_OFF,     3'd0, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h81},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h80},
        '{CMD_BLINK,   3'd1, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h80},
        '{CMD_TICK,    3'd1, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    3'd2, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    3'd3, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_BLINK,   3'd1, 16'h0000, 8'hFF, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    3'd0, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, 8'h00},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_BLINK,   3'd2, 16'hFFFF, 8'h01, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_CODE,    3'd3, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_CODE,    3'd3, 16'h0000, 8'h00, 8'hFF, 1'b0, 8'h00},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_CODE,    3'd4, 16'hFFFF, 8'hFF, 8'h01, 1'b0, 8'h00},
        '{CMD_OFF,     3'd7, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00}
    };

    logic [15:0] step_set  [NUM_PHASES] = '{16'd1, 16'd65535, 16'd2, 16'd1, 16'd65535, 16'd3};
    logic [15:0] pause_set [NUM_PHASES] = '{16'd1, 16'd65535, 16'd7, 16'd65535, 16'd1, 16'd2};

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %02h expected %02h", cyc, what, got, want);
        err_cnt++;
    endtask

    function automatic void reset_model();
        for (int i = 0; i < NUM_LEDS; i++) begin
            cur_m[i]   = M_IDLE;
            prev_m[i]  = M_IDLE;
            nxt_m[i]   = M_IDLE;
            elap[i]    = '0;
            per_st[i]  = '0;
            str_lim[i] = '0;
            str_cnt[i] = '0;
            phase[i]   = 1'b0;
            code_st[i] = '0;
            prog[i]    = '0;
        end
        lit       = '0;
        step_cfg  = CODE_STEP_RESET;
        pause_cfg = CODE_PAUSE_RESET;
    endfunction

    function automatic void tick_led(input int i);
        if (elap[i] < ELAPSED_TOP) elap[i] = elap[i] + 17'd1;
        case (cur_m[i])
            M_ON: begin
                if (prev_m[i] != M_ON) begin
                    lit[i]   = 1'b1;
                    nxt_m[i] = M_ON;
                end
            end
            M_OFF: begin
                if (prev_m[i] != M_OFF) begin
                    lit[i]   = 1'b0;
                    nxt_m[i] = M_OFF;
                end
            end
            M_BLINK: begin
                if (prev_m[i] != M_BLINK) begin
                    elap[i]  = '0;
                    nxt_m[i] = M_BLINK;
                end
                if (elap[i] > {1'b0, per_st[i]}) begin
                    elap[i] = '0;
                    if (!phase[i]) begin
                        lit[i]   = 1'b0;
                        phase[i] = 1'b1;
                    end else if (str_lim[i] == 8'd0) begin
                        lit[i]   = 1'b1;
                        phase[i] = 1'b0;
                    end else if (str_cnt[i] >= str_lim[i]) begin
                        str_cnt[i] = '0;
                        lit[i]     = 1'b1;
                        phase[i]   = 1'b0;
                    end else begin
                        str_cnt[i] = str_cnt[i] + 8'd1;
                    end
                end
            end
            M_CODE: begin
                if (prev_m[i] != M_CODE) begin
                    elap[i]  = '0;
                    phase[i] = 1'b1;
                    prog[i]  = '0;
                end
                if (elap[i] > {1'b0, step_cfg}) begin
                    elap[i]  = '0;
                    lit[i]   = phase[i];
                    phase[i] = !phase[i];
                    if (prog[i] < {code_st[i], 1'b0}) begin
                        prog[i]  = prog[i] + 9'd1;
                        nxt_m[i] = M_CODE;
                    end else begin
                        lit[i]   = 1'b0;
                        nxt_m[i] = M_PAUSE;
                    end
                end
            end
            M_PAUSE: begin
                if (prev_m[i] != M_PAUSE) begin
                    elap[i]  = '0;
                    phase[i] = 1'b0;
                end
                if (elap[i] > {1'b0, pause_cfg}) nxt_m[i] = M_CODE;
            end
            default: begin
            end
        endcase
        prev_m[i] = cur_m[i];
        cur_m[i]  = nxt_m[i];
    endfunction

    function automatic logic [7:0] predict_levels(input item_t it);
        int n;
        n = int'(it.led_index);
        if (it.mode == CMD_TICK) begin
            for (int i = 0; i < NUM_LEDS; i++) tick_led(i);
        end else if (n < NUM_LEDS) begin
            case (it.mode)
                CMD_ON:  cur_m[n] = M_ON;
                CMD_OFF: cur_m[n] = M_OFF;
                CMD_BLINK: begin
                    if (prev_m[n] != M_BLINK) begin
                        elap[n]  = '0;
                        cur_m[n] = M_BLINK;
                    end
                    per_st[n]  = it.blink_period;
                    str_lim[n] = it.stretch_steps;
                end
                CMD_CODE: begin
                    if (prev_m[n] != M_CODE) begin
                        elap[n]  = '0;
                        cur_m[n] = M_CODE;
                        nxt_m[n] = M_CODE;
                    end
                    code_st[n] = it.code_value;
                    prog[n]    = '0;
                end
                default: begin
                end
            endcase
        end
        return lit;
    endfunction

    function automatic int pick_gap();
        int pick;
        if (snd_calm > 0) begin
            snd_calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 65) begin
            snd_calm = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        pick             = $urandom_range(0, 99);
        it.led_index     = 3'($urandom_range(0, 7));
        it.blink_period  = 16'($urandom_range(0, 65535));
        it.stretch_steps = 8'($urandom_range(0, 255));
        it.code_value    = 8'($urandom_range(0, 255));
        if (pick < 65) begin
            it.mode = CMD_TICK;
        end else if (pick < 71) begin
            it.mode = CMD_ON;
        end else if (pick < 77) begin
            it.mode = CMD_OFF;
        end else if (pick < 87) begin
            it.mode = CMD_BLINK;
            pick    = $urandom_range(0, 99);
            if (pick < 80) it.blink_period = 16'($urandom_range(0, 4));
            else if (pick < 90) it.blink_period = 16'hFFFF;
            pick = $urandom_range(0, 99);
            if (pick < 70) it.stretch_steps = 8'($urandom_range(0, 3));
            else if (pick < 85) it.stretch_steps = 8'hFF;
        end else if (pick < 97) begin
            it.mode = CMD_CODE;
            if ($urandom_range(0, 99) < 80) it.code_value = 8'($urandom_range(0, 3));
        end else begin
            it.mode = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        end
        return it;
    endfunction

    task automatic push_beat(input item_t it, input bit typed, input logic [7:0] levels,
                             input int gap);
        logic [7:0] model_levels;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_levels = predict_levels(it);
        pending_levels.push_back(typed ? levels : model_levels);
        beat_cnt++;
        if (it.mode == CMD_TICK) tick_cnt++;
        else cmd_cnt++;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_CODE_STEP) step_cfg = val;
        else pause_cfg = val;
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cyc,
                     pending_levels.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side ready, with short and long stalls and forced holds
    initial begin
        int pick;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                rcv_stall = LONG_HOLD;
                rcv_calm  = 0;
                hold_cnt++;
            end
            if (rcv_stall > 0) begin
                rcv_stall--;
                m_tready <= 1'b0;
            end else if (rcv_calm > 0) begin
                rcv_calm--;
                m_tready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    m_tready <= 1'b1;
                end else if (pick < 65) begin
                    rcv_calm = $urandom_range(20, 80);
                    m_tready <= 1'b1;
                end else if (pick < 95) begin
                    rcv_stall = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    rcv_stall = $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_cnt++;
            if (pending_levels.size() == 0) begin
                report_mismatch("led_levels beat with nothing pending", m_tdata, 8'h00);
            end else begin
                want_levels = pending_levels.pop_front();
                if (m_tdata !== want_levels) report_mismatch("led_levels", m_tdata, want_levels);
            end
        end
    end

    initial begin
        item_t it;
        reset_model();
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_CODE_STEP;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        setting_cnt = 1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            it.mode          = dir_tab[r].mode;
            it.led_index     = dir_tab[r].idx;
            it.blink_period  = dir_tab[r].period;
            it.stretch_steps = dir_tab[r].stretch;
            it.code_value    = dir_tab[r].code;
            push_beat(it, dir_tab[r].typed, dir_tab[r].levels, pick_gap());
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            // sender waits here until every level word is back
            drain();
            write_reg(REG_CODE_STEP, step_set[p]);
            write_reg(REG_CODE_PAUSE, pause_set[p]);
            setting_cnt++;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (k == 10 && (p == 2 || p == 5)) begin
                    hold_req = 1'b1;
                    snd_calm = 60;
                end
                push_beat(rand_item(), 1'b0, 8'h00, pick_gap());
            end
        end

        drain();
        $display("sent %0d beats (%0d ticks, %0d commands) under %0d code step/pause settings",
                 beat_cnt, tick_cnt, cmd_cnt, setting_cnt);
        $display("checked %0d level words, %0d long receiver holds, %0d mismatches",
                 result_cnt, hold_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
